@@ design/led_pkg.sv @@
// ----------------------------------------------------------------------------
// led_pkg
// Shared types, codes and helpers for the edit distance chain.
// ----------------------------------------------------------------------------
`default_nettype none

package led_pkg;

    localparam int DEF_MAX_FIRST_LEN  = 64;
    localparam int DEF_MAX_SECOND_LEN = 65535;
    localparam int DEF_SYMBOL_BITS    = 8;

    localparam int COST_W = 16;
    localparam logic [COST_W-1:0] COST_MAX = 16'hFFFF;

    // Input action codes
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_STREAM = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    typedef enum logic [1:0] {
        TK_NONE,
        TK_LOAD,
        TK_STREAM,
        TK_FINISH
    } t_kind;

    // Control part of the token that walks down the chain
    typedef struct packed {
        t_kind      kind;
        logic [1:0] status;
    } t_ctl;

    function automatic logic [COST_W-1:0] sat_inc(input logic [COST_W-1:0] v);
        return (v == COST_MAX) ? COST_MAX : COST_W'(v + 1'b1);
    endfunction

endpackage

`default_nettype wire

@@ design/led_cell.sv @@
// ----------------------------------------------------------------------------
// led_cell
// One row of the cost matrix: holds a first-string symbol and its cost.
// ----------------------------------------------------------------------------
`default_nettype none

module led_cell #(
    parameter int CELL_IDX    = 1,
    parameter int SYMBOL_BITS = 8,
    parameter int IDX_W       = 7
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_adv,
    input  wire led_pkg::t_ctl            i_ctl,
    input  wire logic [SYMBOL_BITS-1:0]   i_symbol,
    input  wire logic [IDX_W-1:0]         i_idx,
    input  wire logic [15:0]              i_above,
    input  wire logic [15:0]              i_diag,
    output led_pkg::t_ctl                 o_ctl,
    output logic [SYMBOL_BITS-1:0]        o_symbol,
    output logic [IDX_W-1:0]              o_idx,
    output logic [15:0]                   o_above,
    output logic [15:0]                   o_diag
);
    import led_pkg::*;

    localparam logic [IDX_W-1:0]  MY_IDX   = IDX_W'(CELL_IDX);
    localparam logic [COST_W-1:0] RST_COST = COST_W'(CELL_IDX);

    logic [SYMBOL_BITS-1:0] r_sym, n_sym;
    logic [COST_W-1:0]      r_cost, n_cost;
    t_ctl                   r_ctl;
    logic [SYMBOL_BITS-1:0] r_symbol;
    logic [IDX_W-1:0]       r_idx;
    logic [COST_W-1:0]      r_above, n_above;
    logic [COST_W-1:0]      r_diag, n_diag;

    logic                   w_hit;
    logic [COST_W-1:0]      w_sub, w_ins, w_del, w_m, w_min;

    always_comb begin
        w_hit = (i_idx == MY_IDX);
        w_sub = (i_symbol == r_sym) ? i_diag : sat_inc(i_diag);
        w_ins = sat_inc(r_cost);
        w_del = sat_inc(i_above);
        w_m   = (w_ins < w_del) ? w_ins : w_del;
        w_min = (w_sub < w_m) ? w_sub : w_m;

        n_sym   = r_sym;
        n_cost  = r_cost;
        n_above = i_above;
        n_diag  = i_diag;
        unique case (i_ctl.kind)
            TK_LOAD: begin
                if (w_hit) begin
                    n_sym = i_symbol;
                end
            end
            TK_STREAM: begin
                n_cost  = w_min;
                n_above = w_min;
                n_diag  = r_cost;
            end
            TK_FINISH: begin
                // The finish token carries the distance in its above lane
                if (w_hit) begin
                    n_above = r_cost;
                end
                n_cost = RST_COST;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost <= RST_COST;
            r_ctl  <= '{kind: TK_NONE, status: ST_OK};
        end else if (i_adv) begin
            r_cost <= n_cost;
            r_ctl  <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sym    <= n_sym;
            r_symbol <= i_symbol;
            r_idx    <= i_idx;
            r_above  <= n_above;
            r_diag   <= n_diag;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_symbol = r_symbol;
    assign o_idx    = r_idx;
    assign o_above  = r_above;
    assign o_diag   = r_diag;

endmodule

`default_nettype wire

@@ design/levenshtein_edit_distance.sv @@
// ----------------------------------------------------------------------------
// levenshtein_edit_distance
// Unit-cost edit distance engine built as a systolic row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall, i_action, i_symbol): load the first
//   string symbol by symbol, then stream the second string, then send a
//   finish. Unless stalled, one input transfer per cycle; every item enters
//   the cell row at once and walks one cell per cycle, so streams overlap.
//   Output channel (o_valid / i_stall, o_distance, o_status): one transfer per
//   finish, registered in the result slot once the finish token has crossed
//   every cell of the row. Loads and streams give no result.
//   The finish token collects the cost of the last loaded cell and returns
//   every cell it passes to its reset cost, so the next pair may start in the
//   cycle after the finish.
//   While a result waits and i_stall is high, the whole row holds and
//   o_stall is raised; otherwise the block takes one item per cycle.
//   Reset (i_rst_n low, synchronous) clears the counters, flags and all
//   cell costs together; no clearing pass follows.
// ----------------------------------------------------------------------------
`default_nettype none

module levenshtein_edit_distance #(
    parameter int MAX_FIRST_LEN  = led_pkg::DEF_MAX_FIRST_LEN,
    parameter int MAX_SECOND_LEN = led_pkg::DEF_MAX_SECOND_LEN,
    parameter int SYMBOL_BITS    = led_pkg::DEF_SYMBOL_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_symbol,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_distance,
    output logic [1:0]       o_status
);
    import led_pkg::*;

    localparam int IDX_W = $clog2(MAX_FIRST_LEN + 1);
    localparam int SL_W  = $clog2(MAX_SECOND_LEN + 1);
    localparam int FLAG_TRUNC = 0;
    localparam int FLAG_ORDER = 1;

    // Pair bookkeeping
    logic [IDX_W-1:0]  r_first_len, n_first_len;
    logic [SL_W-1:0]   r_second_len, n_second_len;
    logic [1:0]        r_flags, n_flags;
    logic [COST_W-1:0] r_cost0, n_cost0;

    // Result slot
    logic              r_o_valid;
    logic [COST_W-1:0] r_o_distance;
    logic [1:0]        r_o_status;

    logic              w_adv;
    logic              w_accept;
    logic [1:0]        w_status;

    // Token lanes; entry 0 is the injection point, entry g is cell g's output
    t_ctl                   w_ctl    [0:MAX_FIRST_LEN];
    logic [SYMBOL_BITS-1:0] w_symbol [0:MAX_FIRST_LEN];
    logic [IDX_W-1:0]       w_idx    [0:MAX_FIRST_LEN];
    logic [COST_W-1:0]      w_above  [0:MAX_FIRST_LEN];
    logic [COST_W-1:0]      w_diag   [0:MAX_FIRST_LEN];

    // The row moves whenever the result slot can take what leaves it
    assign w_adv    = !r_o_valid || !i_stall;
    assign o_stall  = !w_adv;
    assign w_accept = i_valid && w_adv;

    always_comb begin
        // Order error wins over truncation
        priority if (r_flags[FLAG_ORDER]) begin
            w_status = ST_ORDER;
        end else if (r_flags[FLAG_TRUNC]) begin
            w_status = ST_TRUNC;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        n_first_len  = r_first_len;
        n_second_len = r_second_len;
        n_flags      = r_flags;
        n_cost0      = r_cost0;

        w_ctl[0]    = '{kind: TK_NONE, status: w_status};
        w_symbol[0] = SYMBOL_BITS'(i_symbol);
        w_idx[0]    = '0;
        w_above[0]  = r_cost0;
        w_diag[0]   = r_cost0;

        if (w_accept) begin
            unique case (i_action)
                ACT_LOAD: begin
                    // Drop loads once streaming began or the row is full
                    priority if (r_second_len != '0) begin
                        n_flags[FLAG_ORDER] = 1'b1;
                    end else if (r_first_len == IDX_W'(MAX_FIRST_LEN)) begin
                        n_flags[FLAG_TRUNC] = 1'b1;
                    end else begin
                        w_ctl[0].kind = TK_LOAD;
                        w_idx[0]      = IDX_W'(r_first_len + 1'b1);
                        n_first_len   = IDX_W'(r_first_len + 1'b1);
                    end
                end
                ACT_STREAM: begin
                    // Drop silently at the second-string bound
                    if (r_second_len != SL_W'(MAX_SECOND_LEN)) begin
                        n_second_len  = SL_W'(r_second_len + 1'b1);
                        n_cost0       = sat_inc(r_cost0);
                        w_ctl[0].kind = TK_STREAM;
                        w_above[0]    = n_cost0;
                        w_diag[0]     = r_cost0;
                    end
                end
                ACT_FINISH: begin
                    // Row zero is the boundary cost; above already holds it
                    w_ctl[0].kind = TK_FINISH;
                    w_idx[0]      = r_first_len;
                    n_first_len   = '0;
                    n_second_len  = '0;
                    n_flags       = '0;
                    n_cost0       = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_len  <= '0;
            r_second_len <= '0;
            r_flags      <= '0;
            r_cost0      <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_first_len  <= n_first_len;
            r_second_len <= n_second_len;
            r_flags      <= n_flags;
            r_cost0      <= n_cost0;
            if (w_adv) begin
                r_o_valid <= (w_ctl[MAX_FIRST_LEN].kind == TK_FINISH);
            end
        end
    end

    // Capture the finish token as it leaves the last cell
    always_ff @(posedge i_clk) begin
        if (w_adv && (w_ctl[MAX_FIRST_LEN].kind == TK_FINISH)) begin
            r_o_distance <= w_above[MAX_FIRST_LEN];
            r_o_status   <= w_ctl[MAX_FIRST_LEN].status;
        end
    end

    for (genvar g = 1; g <= MAX_FIRST_LEN; g++) begin : g_cell
        led_cell #(
            .CELL_IDX    (g),
            .SYMBOL_BITS (SYMBOL_BITS),
            .IDX_W       (IDX_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_ctl    (w_ctl[g-1]),
            .i_symbol (w_symbol[g-1]),
            .i_idx    (w_idx[g-1]),
            .i_above  (w_above[g-1]),
            .i_diag   (w_diag[g-1]),
            .o_ctl    (w_ctl[g]),
            .o_symbol (w_symbol[g]),
            .o_idx    (w_idx[g]),
            .o_above  (w_above[g]),
            .o_diag   (w_diag[g])
        );
    end

    assign o_valid    = r_o_valid;
    assign o_distance = r_o_distance;
    assign o_status   = r_o_status;

`ifndef SYNTHESIS
    a_first_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first_len <= IDX_W'(MAX_FIRST_LEN))
        else $error("first length beyond cell row");

    a_cost0_tracks_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_second_len == '0) == (r_cost0 == '0))
        else $error("boundary cost out of step with second length");

    a_first_len_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_second_len != '0) |=>
            (r_first_len == $past(r_first_len) || r_first_len == '0))
        else $error("first string grew after streaming began");
`endif

endmodule

`default_nettype wire
